// File: rtl/abpwd_pkg.sv
// Shared types and constants for the alarm-bus panel word decoder.
// No dependencies; imported by the top level, the front end and the back end.
package abpwd_pkg;

   localparam int ABPWD_MAX_WORD_BITS = 127;
   localparam int ABPWD_QUEUE_DEPTH   = 2;

   localparam logic [19:0] GAP_RESET_US  = 20'd5200;
   localparam logic [31:0] GAP_MARGIN_US = 32'd200;
   localparam int          MIN_WORD_BITS = 8;

   localparam logic [7:0] CMD_NONE   = 8'h00;
   localparam logic [7:0] CMD_ZONE_0 = 8'h27;
   localparam logic [7:0] CMD_ZONE_1 = 8'h2d;
   localparam logic [7:0] CMD_ZONE_2 = 8'h34;
   localparam logic [7:0] CMD_ZONE_3 = 8'h3e;

   localparam logic [2:0] GRP_ZONE_0 = 3'd0;
   localparam logic [2:0] GRP_ZONE_1 = 3'd1;
   localparam logic [2:0] GRP_ZONE_2 = 3'd2;
   localparam logic [2:0] GRP_ZONE_3 = 3'd3;
   localparam logic [2:0] GRP_NONE   = 3'd4;

   localparam logic [1:0] ARM_NONE     = 2'd0;
   localparam logic [1:0] ARM_ARMED    = 2'd2;
   localparam logic [1:0] ARM_DISARMED = 2'd3;

   localparam logic [7:0] USER_ARM_OFFSET = 8'h19;
   localparam logic [7:0] USER_SKIP_LIMIT = 8'd34;
   localparam logic [7:0] USER_SKIP_STEP  = 8'd5;

   localparam logic [3:0] YEAR_TWO_DIGIT = 4'd10;

   typedef struct packed {
      logic        clock_level;
      logic        data_bit;
      logic [31:0] time_us;
   } req_type;

   typedef struct packed {
      logic [7:0]  panel_cmd;
      logic [6:0]  status_flags;
      logic [2:0]  zone_group;
      logic [7:0]  zone_bits;
      logic [10:0] year_value;
      logic [3:0]  month_value;
      logic [4:0]  day_value;
      logic [4:0]  hour_value;
      logic [5:0]  minute_value;
      logic [1:0]  arm_state;
      logic        master_code;
      logic [7:0]  user_code;
   } rsp_type;

endpackage

// File: rtl/alarm_bus_panel_word_decoder.sv
// Top level of the alarm-bus panel word decoder: front, word queue, back,
// result queue. Depends on abpwd_pkg, abpwd_front, abpwd_back, abpwd_fifo.
//
// Usage:
//  - Input channel: one item per alarm-bus clock edge (level after the edge,
//    data bit, microsecond timestamp). Push it while full is low; one item
//    is taken every cycle while full is low.
//  - Result channel: a decoded panel word is on rsp_item while empty is low;
//    pop takes it. Words with a zero command or equal to the last emitted
//    word give no result.
//  - csr_we writes the word gap setting; write only while the block is idle.
//  - The edge that closes a word yields its result by way of the word queue
//    and then the result queue.
//  - Throughput: one edge per cycle while full is low; the back end decodes
//    one closed word per cycle while the result queue is not full.
//  - When the receiver stalls, results collect in the result queue, then
//    closed words in the word queue; once that fills, full goes high.
//  - Reset clears the word builder, the last emitted word, the timestamp and
//    both queues, and loads the gap setting with its default.
module alarm_bus_panel_word_decoder #(
   parameter int MAX_WORD_BITS = abpwd_pkg::ABPWD_MAX_WORD_BITS,
   parameter int QUEUE_DEPTH   = abpwd_pkg::ABPWD_QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [19:0]        csr_wdata,
   input  logic               push,
   input  abpwd_pkg::req_type req_item,
   output logic               full,
   output logic               empty,
   input  logic               pop,
   output abpwd_pkg::rsp_type rsp_item
);

   import abpwd_pkg::*;

   localparam int WORD_SLOTS = MAX_WORD_BITS + 1;
   localparam int COUNT_W    = $clog2(MAX_WORD_BITS + 2);
   localparam int WORD_W     = COUNT_W + WORD_SLOTS;
   localparam int RSP_W      = $bits(rsp_type);

   logic              word_push, word_full, word_pop, word_empty;
   logic [WORD_W-1:0] word_in, word_out;
   logic              rsp_push, rsp_full;
   rsp_type           rsp_data;
   logic [RSP_W-1:0]  rsp_bits;

   abpwd_front #(
      .MAX_WORD_BITS(MAX_WORD_BITS),
      .WORD_SLOTS   (WORD_SLOTS),
      .COUNT_W      (COUNT_W)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .csr_we   (csr_we),
      .csr_wdata(csr_wdata),
      .req_push (push),
      .req_item (req_item),
      .req_full (full),
      .word_push(word_push),
      .word_data(word_in),
      .word_full(word_full)
   );

   abpwd_fifo #(
      .WIDTH(WORD_W),
      .DEPTH(QUEUE_DEPTH)
   ) u_word_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (word_push),
      .push_data(word_in),
      .full     (word_full),
      .pop      (word_pop),
      .pop_data (word_out),
      .empty    (word_empty)
   );

   abpwd_back #(
      .MAX_WORD_BITS(MAX_WORD_BITS),
      .WORD_SLOTS   (WORD_SLOTS),
      .COUNT_W      (COUNT_W)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .word_data (word_out),
      .word_empty(word_empty),
      .word_pop  (word_pop),
      .rsp_push  (rsp_push),
      .rsp_data  (rsp_data),
      .rsp_full  (rsp_full)
   );

   abpwd_fifo #(
      .WIDTH(RSP_W),
      .DEPTH(QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (rsp_push),
      .push_data(rsp_data),
      .full     (rsp_full),
      .pop      (pop),
      .pop_data (rsp_bits),
      .empty    (empty)
   );

   assign rsp_item = rsp_type'(rsp_bits);

endmodule

// File: rtl/abpwd_fifo.sv
// Small first-in first-out queue of fixed-width items.
// Standalone; used between the front and back and on the result side.
module abpwd_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: rtl/abpwd_front.sv
// Front end: edge intake, gap timing and panel word assembly.
// Uses abpwd_pkg; hands closed words (length and bits) to the word queue.
module abpwd_front #(
   parameter int MAX_WORD_BITS = 127,
   parameter int WORD_SLOTS    = MAX_WORD_BITS + 1,
   parameter int COUNT_W       = $clog2(MAX_WORD_BITS + 2)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [19:0]                   csr_wdata,
   input  logic                          req_push,
   input  abpwd_pkg::req_type            req_item,
   output logic                          req_full,
   output logic                          word_push,
   output logic [COUNT_W+WORD_SLOTS-1:0] word_data,
   input  logic                          word_full
);

   import abpwd_pkg::*;

   localparam int IDX_W = $clog2(WORD_SLOTS);

   logic [19:0]           word_gap_ff, word_gap_in;
   logic [31:0]           last_time_ff, last_time_in;
   logic [WORD_SLOTS-1:0] build_bits_ff, build_bits_in;
   logic [COUNT_W-1:0]    build_count_ff, build_count_in;
   logic [31:0]           gap, threshold;
   logic [WORD_SLOTS-1:0] base_bits;
   logic [COUNT_W-1:0]    base_count;
   logic                  accept, close;

   assign req_full  = word_full;
   assign accept    = req_push && !req_full;
   assign gap       = req_item.time_us - last_time_ff;
   assign threshold = 32'(word_gap_ff) + GAP_MARGIN_US;
   assign close     = accept && (gap >= threshold) &&
                      (build_count_ff >= COUNT_W'(MIN_WORD_BITS));
   assign word_push = close;
   assign word_data = {build_count_ff, build_bits_ff};

   always_comb begin
      word_gap_in    = csr_we ? csr_wdata : word_gap_ff;
      last_time_in   = last_time_ff;
      build_bits_in  = build_bits_ff;
      build_count_in = build_count_ff;
      // close the old word before storing this edge's bit
      base_bits      = close ? '0 : build_bits_ff;
      base_count     = close ? '0 : build_count_ff;
      if (accept) begin
         last_time_in   = req_item.time_us;
         build_bits_in  = base_bits;
         build_count_in = base_count;
         if (req_item.clock_level && (base_count <= COUNT_W'(MAX_WORD_BITS))) begin
            build_bits_in[base_count[IDX_W-1:0]] = req_item.data_bit;
            build_count_in = base_count + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_gap_ff    <= GAP_RESET_US;
         last_time_ff   <= '0;
         build_bits_ff  <= '0;
         build_count_ff <= '0;
      end else begin
         word_gap_ff    <= word_gap_in;
         last_time_ff   <= last_time_in;
         build_bits_ff  <= build_bits_in;
         build_count_ff <= build_count_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      build_count_ff <= COUNT_W'(WORD_SLOTS))
      else $error("word length past slot count");

   a_close_restart: assert property (@(posedge clock) disable iff (reset)
      close |=> build_count_ff <= COUNT_W'(1))
      else $error("word not restarted after close");

   a_unused_clear: assert property (@(posedge clock) disable iff (reset)
      (build_count_ff == '0) |-> (build_bits_ff == '0))
      else $error("stale bits in empty word");

endmodule

// File: rtl/abpwd_back.sv
// Back end: repeat filter against the last emitted word and field decode.
// Uses abpwd_pkg; reads the word queue, writes the result queue.
module abpwd_back #(
   parameter int MAX_WORD_BITS = 127,
   parameter int WORD_SLOTS    = MAX_WORD_BITS + 1,
   parameter int COUNT_W       = $clog2(MAX_WORD_BITS + 2)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [COUNT_W+WORD_SLOTS-1:0] word_data,
   input  logic                          word_empty,
   output logic                          word_pop,
   output logic                          rsp_push,
   output abpwd_pkg::rsp_type            rsp_data,
   input  logic                          rsp_full
);

   import abpwd_pkg::*;

   logic [WORD_SLOTS-1:0] prior_bits_ff, prior_bits_in;
   logic [COUNT_W-1:0]    prior_count_ff, prior_count_in;
   logic [WORD_SLOTS-1:0] w;
   logic [COUNT_W-1:0]    len;
   logic [7:0]            cmd;
   logic                  repeat_word, drop;
   logic [3:0]            year_hi, year_lo;
   logic [10:0]           year_scale;
   logic [1:0]            arm;
   logic [7:0]            user;

   assign w   = word_data[WORD_SLOTS-1:0];
   assign len = word_data[COUNT_W+WORD_SLOTS-1:WORD_SLOTS];
   assign cmd = {w[0], w[1], w[2], w[3], w[4], w[5], w[6], w[7]};

   assign repeat_word = (len == prior_count_ff) && (w == prior_bits_ff);
   assign drop        = (cmd == CMD_NONE) || repeat_word;
   // dropped words leave without waiting on the result queue
   assign word_pop    = !word_empty && (drop || !rsp_full);
   assign rsp_push    = !word_empty && !drop && !rsp_full;

   assign year_hi    = {w[9], w[10], w[11], w[12]};
   assign year_lo    = {w[13], w[14], w[15], w[16]};
   assign year_scale = (year_lo >= YEAR_TWO_DIGIT) ? 11'd100 : 11'd10;
   assign arm        = {w[41], w[42]};

   always_comb begin
      user = {2'b00, w[43], w[44], w[45], w[46], w[47], w[48]};
      if (arm == ARM_ARMED) begin
         user = user - USER_ARM_OFFSET;
      end
      if (arm != ARM_NONE) begin
         user = user + 8'd1;
         if (user > USER_SKIP_LIMIT) begin
            user = user + USER_SKIP_STEP;
         end
      end else begin
         user = '0;
      end
   end

   always_comb begin
      rsp_data.panel_cmd    = cmd;
      rsp_data.status_flags = {w[29], w[17], w[15], w[14], w[13], w[12], w[16]};
      unique case (cmd)
         CMD_ZONE_0: rsp_data.zone_group = GRP_ZONE_0;
         CMD_ZONE_1: rsp_data.zone_group = GRP_ZONE_1;
         CMD_ZONE_2: rsp_data.zone_group = GRP_ZONE_2;
         CMD_ZONE_3: rsp_data.zone_group = GRP_ZONE_3;
         default:    rsp_data.zone_group = GRP_NONE;
      endcase
      rsp_data.zone_bits    = {w[41], w[42], w[43], w[44], w[45], w[46], w[47], w[48]};
      rsp_data.year_value   = 11'(year_hi) * year_scale + 11'(year_lo);
      rsp_data.month_value  = {w[19], w[20], w[21], w[22]};
      rsp_data.day_value    = {w[23], w[24], w[25], w[26], w[27]};
      rsp_data.hour_value   = {w[28], w[29], w[30], w[31], w[32]};
      rsp_data.minute_value = {w[33], w[34], w[35], w[36], w[37], w[38]};
      rsp_data.arm_state    = arm;
      rsp_data.master_code  = w[43];
      rsp_data.user_code    = user;
   end

   always_comb begin
      prior_bits_in  = prior_bits_ff;
      prior_count_in = prior_count_ff;
      if (rsp_push) begin
         prior_bits_in  = w;
         prior_count_in = len;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prior_bits_ff  <= '0;
         prior_count_ff <= '0;
      end else begin
         prior_bits_ff  <= prior_bits_in;
         prior_count_ff <= prior_count_in;
      end
   end

   a_cmd_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> rsp_data.panel_cmd != CMD_NONE)
      else $error("zero command emitted");

   a_prior_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_push |=> (prior_count_ff == $past(len)) && (prior_bits_ff == $past(w)))
      else $error("prior word not updated on emit");

   a_prior_hold: assert property (@(posedge clock) disable iff (reset)
      !rsp_push |=> $stable(prior_count_ff) && $stable(prior_bits_ff))
      else $error("prior word changed without emit");

endmodule
